### sv/bqg_pkg.sv
// ----------------------------------------------------------------------------
// bqg_pkg: shared types and constants for the gliding biquad
// Widths, operation codes, coefficient indexes and the structs that pass
// between the sequencer, the coefficient bank and the multiplier unit.
// ----------------------------------------------------------------------------
package bqg_pkg;

    // default parameter values
    localparam int DEF_GLIDE_STEPS    = 256;
    localparam int DEF_COEF_FRAC_BITS = 28;

    // fixed field widths
    localparam int SAMPLE_W        = 32;
    localparam int COEF_W          = 32;
    localparam int NUM_COEF        = 5;
    localparam int IDX_W           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int OP_W            = 2;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int OPND_W          = COEF_W + 1;
    localparam int PROD_W          = 2 * OPND_W;
    localparam int ACC_W           = 64;

    // operation codes, code 3 behaves as filter only
    typedef enum logic [OP_W-1:0] {
        OP_FILTER = 2'd0,
        OP_LOAD   = 2'd1,
        OP_GLIDE  = 2'd2
    } op_t;

    // coefficient indexes, plus the pipeline drain slot
    localparam logic [IDX_W-1:0] IDX_B0    = 3'd0;
    localparam logic [IDX_W-1:0] IDX_B1    = 3'd1;
    localparam logic [IDX_W-1:0] IDX_B2    = 3'd2;
    localparam logic [IDX_W-1:0] IDX_A1    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_A2    = 3'd4;
    localparam logic [IDX_W-1:0] IDX_DRAIN = 3'd5;

    // channel payloads
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [OP_W-1:0]            operation;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       overflow;
        logic                       gliding;
    } result_t;

    // sequencer to coefficient bank
    typedef struct packed {
        logic            apply_op;
        logic [OP_W-1:0] op;
        logic            snap;
        logic            advance;
    } bank_cmd_t;

    // coefficient bank to sequencer
    typedef struct packed {
        logic glide_on;
        logic last_step;
    } bank_stat_t;

    // work issued to the shared multiplier
    typedef struct packed {
        logic             valid;
        logic             upd;
        logic             first;
        logic             sub;
        logic [IDX_W-1:0] idx;
    } mul_tag_t;

    // coefficient write-back from the multiplier unit
    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] value;
    } coef_wb_t;

endpackage

### sv/bqg_stream_if.sv
// ----------------------------------------------------------------------------
// bqg_stream_if: valid/ready stream channel
// Carries one payload per transaction; a transaction completes at a rising
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bqg_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

### sv/bqg_coef_bank.sv
// ----------------------------------------------------------------------------
// bqg_coef_bank: coefficient storage and glide position
// Holds the target registers, glide targets, active coefficients and the
// glide step with its scale, kept by a running quotient and remainder.
// ----------------------------------------------------------------------------
module bqg_coef_bank
    import bqg_pkg::*;
#(
    parameter int GLIDE_STEPS = DEF_GLIDE_STEPS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    input  bank_cmd_t                cmd,
    input  coef_wb_t                 wb,
    input  logic [IDX_W-1:0]         rd_idx,
    output logic signed [COEF_W-1:0] coef,
    output logic signed [COEF_W-1:0] target,
    output logic [SCALE_FRAC_BITS-1:0] scale,
    output bank_stat_t               stat
);

    localparam int STEP_W  = $clog2(GLIDE_STEPS);
    localparam int REM_W   = STEP_W + 1;
    localparam int SCALE_Q = (1 << SCALE_FRAC_BITS) / GLIDE_STEPS;
    localparam int SCALE_R = (1 << SCALE_FRAC_BITS) % GLIDE_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GLIDE_STEPS - 1);

    logic signed [COEF_W-1:0] tgt_cfg_reg   [NUM_COEF];
    logic signed [COEF_W-1:0] glide_tgt_reg [NUM_COEF];
    logic signed [COEF_W-1:0] active_reg    [NUM_COEF];
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic [SCALE_FRAC_BITS-1:0] scale_reg;
    logic [SCALE_FRAC_BITS-1:0] scale_next;
    logic [REM_W-1:0]           rem_reg;
    logic [REM_W-1:0]           rem_next;
    logic [REM_W-1:0]           rem_sum;
    logic                       glide_on_reg;

    // read port for the sequencer, drain slot reads zero
    always_comb
    begin
        coef   = '0;
        target = '0;
        if (rd_idx < IDX_W'(NUM_COEF))
        begin
            coef   = active_reg[rd_idx];
            target = glide_tgt_reg[rd_idx];
        end
    end

    assign scale          = scale_reg;
    assign stat.glide_on  = glide_on_reg;
    assign stat.last_step = (step_reg == LAST_STEP);

    // scale = floor(step * 2^16 / steps), stepped without a divider
    always_comb
    begin
        step_next = step_reg + STEP_W'(1);
        rem_sum   = rem_reg + REM_W'(SCALE_R);
        if (rem_sum >= REM_W'(GLIDE_STEPS))
        begin
            rem_next   = rem_sum - REM_W'(GLIDE_STEPS);
            scale_next = scale_reg + SCALE_FRAC_BITS'(SCALE_Q + 1);
        end
        else
        begin
            rem_next   = rem_sum;
            scale_next = scale_reg + SCALE_FRAC_BITS'(SCALE_Q);
        end
    end

    // coefficient and glide state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                tgt_cfg_reg[i]   <= '0;
                glide_tgt_reg[i] <= '0;
                active_reg[i]    <= '0;
            end
            step_reg     <= '0;
            scale_reg    <= '0;
            rem_reg      <= '0;
            glide_on_reg <= 1'b0;
        end
        else
        begin
            // target register writes, unknown indexes dropped
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEF)))
            begin
                tgt_cfg_reg[cfg_index] <= cfg_data;
            end

            if (cmd.apply_op)
            begin
                case (cmd.op)
                    OP_LOAD:
                    begin
                        for (int i = 0; i < NUM_COEF; i++)
                        begin
                            active_reg[i]    <= tgt_cfg_reg[i];
                            glide_tgt_reg[i] <= tgt_cfg_reg[i];
                        end
                        step_reg     <= '0;
                        scale_reg    <= '0;
                        rem_reg      <= '0;
                        glide_on_reg <= 1'b0;
                    end
                    OP_GLIDE:
                    begin
                        for (int i = 0; i < NUM_COEF; i++)
                        begin
                            glide_tgt_reg[i] <= tgt_cfg_reg[i];
                        end
                        step_reg     <= '0;
                        scale_reg    <= '0;
                        rem_reg      <= '0;
                        glide_on_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.snap)
            begin
                // final glide step lands exactly on the targets
                for (int i = 0; i < NUM_COEF; i++)
                begin
                    active_reg[i] <= glide_tgt_reg[i];
                end
                step_reg     <= '0;
                scale_reg    <= '0;
                rem_reg      <= '0;
                glide_on_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                step_reg  <= step_next;
                scale_reg <= scale_next;
                rem_reg   <= rem_next;
            end

            // glided coefficient write-back
            if (wb.en)
            begin
                active_reg[wb.idx] <= wb.value;
            end
        end
    end

    // glide position is at rest whenever no glide runs
    a_step_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !glide_on_reg |-> (step_reg == '0))
        else $error("glide step nonzero with no glide running");

    // scale tracks the step from its zero point
    a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == '0) |-> (scale_reg == '0) && (rem_reg == '0))
        else $error("glide scale out of step with counter");

endmodule

### sv/bqg_mul_unit.sv
// ----------------------------------------------------------------------------
// bqg_mul_unit: shared multiplier with accumulator
// One registered 33x33 signed multiply per cycle; the stage after it either
// writes back a glided coefficient or adds to or subtracts from the 64-bit accumulator.
// ----------------------------------------------------------------------------
module bqg_mul_unit
    import bqg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_tag_t                 issue,
    input  logic signed [OPND_W-1:0] opnd_a,
    input  logic signed [OPND_W-1:0] opnd_b,
    input  logic signed [COEF_W-1:0] hold_in,
    output coef_wb_t                 wb,
    output logic signed [ACC_W-1:0]  acc
);

    mul_tag_t                 tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [COEF_W-1:0] hold_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [PROD_W-1:0] prod_shift;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd_a * opnd_b;
        hold_reg <= hold_in;
        acc_reg  <= acc_next;
    end

    // glide update: c + floor(delta * scale / 2^16)
    assign prod_shift = prod_reg >>> SCALE_FRAC_BITS;
    assign wb.en      = tag_reg.valid && tag_reg.upd;
    assign wb.idx     = tag_reg.idx;
    assign wb.value   = hold_reg + prod_shift[COEF_W-1:0];

    // filter accumulate, wraps modulo 2^64
    always_comb
    begin
        acc_base = tag_reg.first ? '0 : acc_reg;
        acc_next = acc_reg;
        if (tag_reg.valid && !tag_reg.upd)
        begin
            if (tag_reg.sub)
            begin
                acc_next = acc_base - prod_reg[ACC_W-1:0];
            end
            else
            begin
                acc_next = acc_base + prod_reg[ACC_W-1:0];
            end
        end
    end

    assign acc = acc_reg;

endmodule

### sv/bqg_seq.sv
// ----------------------------------------------------------------------------
// bqg_seq: sample sequencer
// Steps one sample through operation, glide update and filter phases,
// feeds the shared multiplier, keeps the delay line and the output register.
// ----------------------------------------------------------------------------
module bqg_seq
    import bqg_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)(
    input  logic                       clk,
    input  logic                       rst_n,
    bqg_stream_if.sink                 item,
    bqg_stream_if.source               result,
    output bank_cmd_t                  cmd,
    output logic [IDX_W-1:0]           rd_idx,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [COEF_W-1:0]   target,
    input  logic [SCALE_FRAC_BITS-1:0] scale,
    input  bank_stat_t                 stat,
    output mul_tag_t                   issue,
    output logic signed [OPND_W-1:0]   opnd_a,
    output logic signed [OPND_W-1:0]   opnd_b,
    output logic signed [COEF_W-1:0]   hold,
    input  logic signed [ACC_W-1:0]    acc
);

    localparam logic signed [ACC_W-1:0] RND_BIAS =
        (ACC_W'(1) << COEF_FRAC_BITS) - ACC_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_FILT = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic signed [SAMPLE_W-1:0] y1_reg;
    logic signed [SAMPLE_W-1:0] y2_reg;
    logic                       out_valid_reg;
    result_t                    out_reg;

    logic                       accept;
    logic                       out_free;
    logic                       fin_load;
    logic signed [SAMPLE_W-1:0] sample_sel;
    logic signed [ACC_W-1:0]    acc_biased;
    logic signed [ACC_W-1:0]    q_full;
    logic                       q_ovf;

    // handshakes
    assign item.ready     = (state_reg == ST_IDLE);
    assign accept         = item.valid && item.ready;
    assign out_free       = !out_valid_reg || result.ready;
    assign fin_load       = (state_reg == ST_FIN) && out_free;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // operation is applied on the accepting edge
    always_comb
    begin
        cmd.apply_op = accept;
        cmd.op       = item.payload.operation;
        cmd.snap     = (state_reg == ST_PREP) && stat.glide_on && stat.last_step;
        cmd.advance  = (state_reg == ST_UPD) && (idx_reg == IDX_DRAIN);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                idx_next = IDX_B0;
                if (stat.glide_on && !stat.last_step)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    state_next = ST_FILT;
                end
            end
            ST_UPD:
            begin
                if (idx_reg == IDX_DRAIN)
                begin
                    idx_next   = IDX_B0;
                    state_next = ST_FILT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FILT:
            begin
                if (idx_reg == IDX_DRAIN)
                begin
                    idx_next   = IDX_B0;
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = IDX_B0;
            end
        endcase
    end

    // delay line tap for the current coefficient
    always_comb
    begin
        case (idx_reg)
            IDX_B0:  sample_sel = x_reg;
            IDX_B1:  sample_sel = x1_reg;
            IDX_B2:  sample_sel = x2_reg;
            IDX_A1:  sample_sel = y1_reg;
            IDX_A2:  sample_sel = y2_reg;
            default: sample_sel = '0;
        endcase
    end

    // multiplier operands and issue tag
    assign rd_idx = idx_reg;
    assign hold   = coef;

    always_comb
    begin
        issue       = '0;
        issue.idx   = idx_reg;
        issue.first = (idx_reg == IDX_B0);
        issue.sub   = (idx_reg == IDX_A1) || (idx_reg == IDX_A2);
        if (state_reg == ST_UPD)
        begin
            issue.valid = (idx_reg != IDX_DRAIN);
            issue.upd   = 1'b1;
            opnd_a      = {target[COEF_W-1], target} - {coef[COEF_W-1], coef};
            opnd_b      = {{(OPND_W - SCALE_FRAC_BITS){1'b0}}, scale};
        end
        else
        begin
            issue.valid = (state_reg == ST_FILT) && (idx_reg != IDX_DRAIN);
            opnd_a      = {coef[COEF_W-1], coef};
            opnd_b      = {sample_sel[SAMPLE_W-1], sample_sel};
        end
    end

    // shift right with rounding toward zero, range check on the quotient
    assign acc_biased = acc + (acc[ACC_W-1] ? RND_BIAS : '0);
    assign q_full     = acc_biased >>> COEF_FRAC_BITS;
    assign q_ovf      = !((&q_full[ACC_W-1:SAMPLE_W-1]) || !(|q_full[ACC_W-1:SAMPLE_W-1]));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_B0;
            out_valid_reg <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
                x1_reg        <= x_reg;
                x2_reg        <= x1_reg;
                y1_reg        <= q_full[SAMPLE_W-1:0];
                y2_reg        <= y1_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample latch and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= item.payload.sample_in;
        end
        if (fin_load)
        begin
            out_reg.sample_out <= q_full[SAMPLE_W-1:0];
            out_reg.overflow   <= q_ovf;
            out_reg.gliding    <= stat.glide_on;
        end
    end

    // an accepted sample always starts its operation phase
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PREP))
        else $error("accepted sample did not enter preparation");

    // a finished sample lands in the output register and frees the input
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished sample not presented");

    // coefficient slot counter stays within the drain slot
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_DRAIN)
        else $error("coefficient slot counter out of range");

endmodule

### sv/biquad_lowpass_coefficient_glide.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_coefficient_glide: direct-form-1 biquad with coefficient glide
// Q4.28 coefficients, signed 32-bit samples, one shared multiplier.
//
//   channel   dir   handshake            payload
//   item      in    valid / ready        sample_in, operation
//   result    out   valid / ready        sample_out, overflow, gliding
//   cfg       in    cfg_we (no ready)    cfg_index, cfg_data
//
// A sample passes from acceptance through preparation, an optional glide
// update phase and the filter phase; the single 33x33 multiplier is used
// for five coefficient updates and then five filter products.
// Reset clears the targets, coefficients, glide state and delay line to zero.
// The input is not ready while a sample is in flight; a full output register
// holds the finished sample's last cycle until the result is taken.
// ----------------------------------------------------------------------------
module biquad_lowpass_coefficient_glide
    import bqg_pkg::*;
#(
    parameter int GLIDE_STEPS    = DEF_GLIDE_STEPS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    bqg_stream_if.sink           item,
    bqg_stream_if.source         result
);

    bank_cmd_t                  cmd;
    bank_stat_t                 stat;
    coef_wb_t                   wb;
    mul_tag_t                   issue;
    logic [IDX_W-1:0]           rd_idx;
    logic signed [COEF_W-1:0]   coef;
    logic signed [COEF_W-1:0]   target;
    logic [SCALE_FRAC_BITS-1:0] scale;
    logic signed [OPND_W-1:0]   opnd_a;
    logic signed [OPND_W-1:0]   opnd_b;
    logic signed [COEF_W-1:0]   hold;
    logic signed [ACC_W-1:0]    acc;

    // coefficient storage and glide position
    bqg_coef_bank #(
        .GLIDE_STEPS (GLIDE_STEPS)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .wb        (wb),
        .rd_idx    (rd_idx),
        .coef      (coef),
        .target    (target),
        .scale     (scale),
        .stat      (stat)
    );

    // shared multiplier and accumulator
    bqg_mul_unit u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .hold_in (hold),
        .wb      (wb),
        .acc     (acc)
    );

    // sample sequencer
    bqg_seq #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .rd_idx (rd_idx),
        .coef   (coef),
        .target (target),
        .scale  (scale),
        .stat   (stat),
        .issue  (issue),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .hold   (hold),
        .acc    (acc)
    );

endmodule

### test/biquad_glide_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_glide_checker: result predictor and comparator for the gliding biquad
// Mirrors the target registers from the config port. Each accepted item
// transaction runs through a local model of the coefficient glide and the
// filter. Each accepted result transaction is compared field by field with the
// oldest prediction. The mismatch count and the number of results still owed
// go back to the testbench top.
// ----------------------------------------------------------------------------
module biquad_glide_checker
    import bqg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  item_t                item_data,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int GLIDE_LEN = DEF_GLIDE_STEPS;
    localparam int FRAC_BITS = DEF_COEF_FRAC_BITS;

    // mirrored registers and filter state
    logic signed [COEF_W-1:0]   target_reg [NUM_COEF];
    logic signed [COEF_W-1:0]   coef_now   [NUM_COEF];
    logic signed [COEF_W-1:0]   coef_goal  [NUM_COEF];
    int                         glide_pos;
    bit                         glide_run;
    logic signed [SAMPLE_W-1:0] x_d1, x_d2, y_d1, y_d2;

    // predicted results, oldest first
    result_t                    predicted_outputs [$];
    int                         mismatches;

    // one sample: operation, then glide update, then the filter
    function automatic result_t filter_sample(input item_t it);
        longint           x, delta, scale, moved, sum, q;
        logic [ACC_W-1:0] acc, mag;
        result_t          res;
        int               i;

        x = longint'($signed(it.sample_in));

        case (it.operation)
            OP_LOAD:
            begin
                for (i = 0; i < NUM_COEF; i++)
                begin
                    coef_now[i]  = target_reg[i];
                    coef_goal[i] = target_reg[i];
                end
                glide_run = 1'b0;
                glide_pos = 0;
            end
            OP_GLIDE:
            begin
                for (i = 0; i < NUM_COEF; i++)
                    coef_goal[i] = target_reg[i];
                glide_pos = 0;
                glide_run = 1'b1;
            end
            default:
            begin
            end
        endcase

        // linear glide, floor of the scaled difference, snap on the last step
        if (glide_run)
        begin
            scale = (longint'(glide_pos) << SCALE_FRAC_BITS) / GLIDE_LEN;
            for (i = 0; i < NUM_COEF; i++)
            begin
                delta       = longint'(coef_goal[i]) - longint'(coef_now[i]);
                moved       = longint'(coef_now[i]) + ((delta * scale) >>> SCALE_FRAC_BITS);
                coef_now[i] = moved[COEF_W-1:0];
            end
            glide_pos++;
            if (glide_pos >= GLIDE_LEN)
            begin
                for (i = 0; i < NUM_COEF; i++)
                    coef_now[i] = coef_goal[i];
                glide_pos = 0;
                glide_run = 1'b0;
            end
        end

        // 64-bit accumulator, wraps on overflow
        sum = longint'(coef_now[IDX_B0]) * x
            + longint'(coef_now[IDX_B1]) * longint'(x_d1)
            + longint'(coef_now[IDX_B2]) * longint'(x_d2)
            - longint'(coef_now[IDX_A1]) * longint'(y_d1)
            - longint'(coef_now[IDX_A2]) * longint'(y_d2);
        acc = sum;

        // shift with rounding toward zero
        if (acc[ACC_W-1])
        begin
            mag = -acc;
            q   = -longint'(mag >> FRAC_BITS);
        end
        else
            q = longint'(acc >> FRAC_BITS);

        res.sample_out = q[SAMPLE_W-1:0];
        res.overflow   = (q != longint'($signed(q[SAMPLE_W-1:0])));
        res.gliding    = glide_run;

        // delay line keeps the wrapped output
        x_d2 = x_d1;
        x_d1 = it.sample_in;
        y_d2 = y_d1;
        y_d1 = q[SAMPLE_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;

        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                target_reg[i] = '0;
                coef_now[i]   = '0;
                coef_goal[i]  = '0;
            end
            glide_pos  = 0;
            glide_run  = 1'b0;
            x_d1       = '0;
            x_d2       = '0;
            y_d1       = '0;
            y_d2       = '0;
            predicted_outputs.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // register write, indexes past the last coefficient are dropped
            if (cfg_we && cfg_index < NUM_COEF)
                target_reg[cfg_index] = cfg_data;

            // item transaction
            if (item_valid && item_ready)
                predicted_outputs.push_back(filter_sample(item_data));

            // result transaction
            if (result_valid && result_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $display("%0t: result with nothing predicted, got out=%0d ovf=%0b gl=%0b",
                             $time, $signed(result_data.sample_out), result_data.overflow,
                             result_data.gliding);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (result_data.sample_out !== want.sample_out)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                                 $signed(want.sample_out), $signed(result_data.sample_out));
                        mismatches++;
                    end
                    if (result_data.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow mismatch, expected %0b, got %0b", $time,
                                 want.overflow, result_data.overflow);
                        mismatches++;
                    end
                    if (result_data.gliding !== want.gliding)
                    begin
                        $display("%0t: gliding mismatch, expected %0b, got %0b", $time,
                                 want.gliding, result_data.gliding);
                        mismatches++;
                    end
                end
            end

            fail_count <= mismatches;
            pending    <= predicted_outputs.size();
        end
    end

endmodule

### test/tb_biquad_lowpass_coefficient_glide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_lowpass_coefficient_glide: stimulus and verdict for the biquad
// A short directed pass hits extreme samples and coefficients, wrap of the
// accumulator, rounding toward zero, code 3, load, glide start and restart.
// Random phases then reprogram the targets and stream samples with rare
// operation changes, so that many glides run to completion. Both channels
// idle at random, and the result side holds off long enough to back up the
// input. Checking lives in biquad_glide_checker.
// ----------------------------------------------------------------------------
module tb_biquad_lowpass_coefficient_glide;
    import bqg_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 20;
    localparam int LIMIT_NS     = 40_000_000;

    // operation code 3 has no function and filters only
    localparam logic [OP_W-1:0]     OP_SPARE = 2'd3;
    localparam logic [SAMPLE_W-1:0] S_MAX    = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN    = 32'h8000_0000;
    localparam logic [COEF_W-1:0]   C_MAX    = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]   C_MIN    = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX [NUM_COEF] =
        '{IDX_B0, IDX_B1, IDX_B2, IDX_A1, IDX_A2};

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_set_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending_results;
    bit                   hold_off_req;
    int                   tx_burst_left;

    bqg_stream_if #(.payload_t(item_t))   item_ch ();
    bqg_stream_if #(.payload_t(result_t)) result_ch ();

    biquad_lowpass_coefficient_glide dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    biquad_glide_checker glide_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .item_data    (item_ch.payload),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.payload),
        .fail_count   (fail_count),
        .pending      (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("tb_biquad_lowpass_coefficient_glide failed");
        $finish;
    end

    function automatic coef_set_t make_set(input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
        coef_set_t c;

        c[IDX_B0] = b0;
        c[IDX_B1] = b1;
        c[IDX_B2] = b2;
        c[IDX_A1] = a1;
        c[IDX_A2] = a2;
        return c;
    endfunction

    // coefficient sets: lowpass-like, full range, extremes, within +/-1.0
    function automatic coef_set_t random_coefs();
        coef_set_t   c;
        int unsigned g, pole;
        int          i;

        case ($urandom_range(0, 3))
            0:
            begin
                g    = $urandom_range(0, 32'h0100_0000);
                pole = $urandom_range(32'h0200_0000, 32'h0F00_0000);
                c = make_set(g, g << 1, g,
                             32'd0 - $urandom_range(0, pole + 32'h1000_0000 - 1), pole);
            end
            1:
            begin
                for (i = 0; i < NUM_COEF; i++)
                    c[i] = $urandom();
            end
            2:
            begin
                for (i = 0; i < NUM_COEF; i++)
                begin
                    case ($urandom_range(0, 4))
                        0:       c[i] = C_MIN;
                        1:       c[i] = C_MAX;
                        2:       c[i] = '0;
                        3:       c[i] = '1;
                        default: c[i] = 32'd1;
                    endcase
                end
            end
            default:
            begin
                for (i = 0; i < NUM_COEF; i++)
                    c[i] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            end
        endcase
        return c;
    endfunction

    // samples: extremes, full range, and audio-like small values
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // mostly filter only, rare load or glide unless the phase is kept clean
    function automatic logic [OP_W-1:0] next_op(input bit clean);
        int r;

        r = $urandom_range(0, 511);
        if (!clean && r == 0)
            return OP_LOAD;
        if (!clean && r == 1)
            return OP_GLIDE;
        if (r < 10)
            return OP_SPARE;
        return OP_FILTER;
    endfunction

    // write all five targets on back-to-back edges, optionally a dead index too
    task automatic program_targets(input coef_set_t c, input bit poke_spare);
        int i;

        for (i = 0; i < NUM_COEF; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_INDEX[i];
            cfg_data  <= c[i];
            @(posedge clk);
        end
        if (poke_spare)
        begin
            cfg_index <= CFG_IDX_W'($urandom_range(NUM_COEF, 2 ** CFG_IDX_W - 1));
            cfg_data  <= $urandom();
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one item transaction, after a random gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [OP_W-1:0] op);
        int    gap;
        int    r;
        item_t it;

        r = $urandom_range(0, 15);
        if (tx_burst_left > 0)
        begin
            gap = 0;
            tx_burst_left--;
        end
        else if (r == 0)
            gap = $urandom_range(20, 60);
        else if (r < 8)
            gap = $urandom_range(1, 3);
        else
            gap = 0;
        if (tx_burst_left == 0 && $urandom_range(0, 63) == 0)
            tx_burst_left = 50;

        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.sample_in      = s;
        it.operation      = op;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // stop offering and wait for every predicted result to come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result side: random ready pattern, long hold-off on request
    initial
    begin
        int run_len;
        int stall_len;

        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 8);
            result_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (hold_off_req)
            begin
                stall_len    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            else if ($urandom_range(0, 15) == 0)
                stall_len = $urandom_range(20, 60);
            else
                stall_len = $urandom_range(1, 3);
            result_ch.ready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int              phase_no;
        int              phase_len;
        int              sent;
        int              n;
        bit              clean;
        logic [OP_W-1:0] op;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        hold_off_req    = 1'b0;
        tx_burst_left   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero coefficients after reset, extreme samples, spare code
        send_sample(S_MAX, OP_FILTER);
        send_sample(S_MIN, OP_FILTER);
        send_sample(32'h5555_5555, OP_SPARE);
        wait_drained();

        // alternating extreme coefficients, output overflow and wrap
        program_targets(make_set(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX), 1'b1);
        send_sample(S_MAX, OP_LOAD);
        send_sample(S_MIN, OP_FILTER);
        send_sample(S_MAX, OP_FILTER);
        send_sample(S_MIN, OP_FILTER);
        send_sample('1, OP_FILTER);
        send_sample(32'd1, OP_FILTER);
        wait_drained();

        // all coefficients most negative, accumulator wraps past 64 bits
        program_targets(make_set(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0);
        send_sample(S_MIN, OP_LOAD);
        send_sample(S_MIN, OP_FILTER);
        send_sample(S_MIN, OP_FILTER);
        send_sample(S_MIN, OP_FILTER);
        wait_drained();

        // tiny coefficients, negative sums round toward zero
        program_targets(make_set(32'd3, -32'sd5, 32'd7, 32'd1, '1), 1'b0);
        send_sample('1, OP_LOAD);
        send_sample(32'd1, OP_FILTER);
        send_sample('1, OP_FILTER);
        send_sample(32'd2, OP_FILTER);
        wait_drained();

        // glide start, restart while gliding, then a load that stops it
        program_targets(make_set(32'h0100_0000, 32'h0200_0000, 32'h0100_0000,
                                 32'hE800_0000, 32'h0C00_0000), 1'b0);
        send_sample(32'd1000, OP_GLIDE);
        send_sample(-32'sd2000, OP_FILTER);
        send_sample(32'd3000, OP_FILTER);
        wait_drained();
        program_targets(make_set(C_MAX, 32'h0800_0000, C_MIN, 32'hF000_0000, C_MAX), 1'b0);
        send_sample(32'd500, OP_GLIDE);
        send_sample(-32'sd500, OP_FILTER);
        send_sample(S_MAX, OP_LOAD);
        wait_drained();

        // random phases, each with fresh targets
        phase_no = 0;
        sent     = 0;
        while (sent < RANDOM_ITEMS)
        begin
            program_targets(random_coefs(), $urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 600);
            clean     = $urandom_range(0, 1);
            if (phase_no == 1 || phase_no == 4)
            begin
                if (phase_len < 300)
                    phase_len = 300;
                hold_off_req = 1'b1;
            end
            // last phase stops at the item budget
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            for (n = 0; n < phase_len; n++)
            begin
                if (n == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_LOAD;
                        3:       op = OP_FILTER;
                        default: op = OP_GLIDE;
                    endcase
                end
                else
                    op = next_op(clean);
                send_sample(random_sample(), op);
            end
            sent += phase_len;
            wait_drained();
            phase_no++;
        end

        if (fail_count == 0)
            $display("tb_biquad_lowpass_coefficient_glide passed");
        else
            $display("tb_biquad_lowpass_coefficient_glide failed");
        $finish;
    end

endmodule

### files.f
sv/bqg_pkg.sv
sv/bqg_stream_if.sv
sv/bqg_coef_bank.sv
sv/bqg_mul_unit.sv
sv/bqg_seq.sv
sv/biquad_lowpass_coefficient_glide.sv
test/biquad_glide_checker.sv
test/tb_biquad_lowpass_coefficient_glide.sv
